FILE: rtl/lcs_pkg.sv
// Shared constants, codes and controller/datapath interface types for the congruence solver.
package lcs_pkg;

    localparam int WIDTH_DEF = 32;
    localparam int STATUS_W  = 2;

    localparam logic [STATUS_W-1:0] ST_SOLVED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZEROMOD = 2'd2;

    localparam logic [1:0] SEL_EUCLID = 2'd0;
    localparam logic [1:0] SEL_CHECK  = 2'd1;
    localparam logic [1:0] SEL_REDUCE = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       div_load;
        logic [1:0] div_sel;
        logic       div_step;
        logic       eu_upd;
        logic       umod;
        logic       st_wr;
        logic [1:0] st_code;
        logic       mul_init;
        logic       mul_dbl;
        logic       mul_add;
        logic       res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic in_mod_zero;
        logic cnt_last;
        logic r1_zero;
        logic rem_zero;
    } t_dp_sts;

endpackage

FILE: rtl/lcs_dp.sv
// Datapath: Euclid registers, shared restoring divider, Bezout product and modular multiplier.
module lcs_dp
    import lcs_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [WIDTH-1:0]    i_coefficient,
    input  logic [WIDTH-1:0]    i_target,
    input  logic [WIDTH-1:0]    i_modulus,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    output logic [WIDTH-1:0]    o_solution,
    output logic [STATUS_W-1:0] o_status
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    function automatic logic [WIDTH-1:0] f_add_mod(
        input logic [WIDTH-1:0] a,
        input logic [WIDTH-1:0] b,
        input logic [WIDTH-1:0] m
    );
        logic [WIDTH-1:0] room;
        begin
            room = m - b;
            if (a >= room) begin
                f_add_mod = a - room;
            end else begin
                f_add_mod = a + b;
            end
        end
    endfunction

    logic [WIDTH-1:0]    r_r0, r_r1, r_s0, r_s1, r_tgt, r_mod;
    logic [WIDTH-1:0]    r_quo, r_rem, r_prod;
    logic [WIDTH-1:0]    r_a, r_b, r_acc;
    logic [WIDTH-1:0]    r_solution;
    logic [STATUS_W-1:0] r_status, r_st;
    logic [1:0]          r_sel;
    logic [CW-1:0]       r_cnt;
    logic                r_odd;

    logic [WIDTH-1:0] w_num, w_den, w_load_den;
    logic [WIDTH:0]   w_sh, w_den_ext, w_diff;
    logic             w_ge;
    logic [WIDTH-1:0] w_umod0, w_umod;

    always_comb begin
        unique case (i_cmd.div_sel)
            SEL_CHECK:  w_num = r_tgt;
            SEL_REDUCE: w_num = r_quo;
            default:    w_num = r_r0;
        endcase
        unique case (r_sel)
            SEL_CHECK:  w_den = r_r0;
            SEL_REDUCE: w_den = r_mod;
            default:    w_den = r_r1;
        endcase
    end

    assign w_load_den = '0;
    assign w_sh       = {r_rem, r_quo[WIDTH-1]};
    assign w_den_ext  = {1'b0, w_den | w_load_den};
    assign w_ge       = (w_sh >= w_den_ext);
    assign w_diff     = w_sh - w_den_ext;

    assign w_umod0 = (r_s0 == r_mod) ? '0 : r_s0;
    assign w_umod  = (r_odd && (w_umod0 != '0)) ? (r_mod - w_umod0) : w_umod0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_r0  <= i_coefficient;
            r_r1  <= i_modulus;
            r_s0  <= WIDTH'(1);
            r_s1  <= '0;
            r_odd <= 1'b0;
            r_tgt <= i_target;
            r_mod <= i_modulus;
            r_st  <= (i_modulus == '0) ? ST_ZEROMOD : ST_SOLVED;
        end
        if (i_cmd.div_load) begin
            r_quo  <= w_num;
            r_rem  <= '0;
            r_prod <= '0;
            r_cnt  <= '0;
            r_sel  <= i_cmd.div_sel;
        end
        if (i_cmd.div_step) begin
            r_quo  <= {r_quo[WIDTH-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[WIDTH-1:0] : w_sh[WIDTH-1:0];
            r_prod <= {r_prod[WIDTH-2:0], 1'b0} + (w_ge ? r_s1 : '0);
            r_cnt  <= r_cnt + CW'(1);
        end
        if (i_cmd.eu_upd) begin
            r_r0  <= r_r1;
            r_r1  <= r_rem;
            r_s0  <= r_s1;
            r_s1  <= r_s0 + r_prod;
            r_odd <= ~r_odd;
        end
        if (i_cmd.umod) begin
            r_a <= w_umod;
        end
        if (i_cmd.st_wr) begin
            r_st <= i_cmd.st_code;
        end
        if (i_cmd.mul_init) begin
            r_b   <= r_rem;
            r_acc <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.mul_dbl) begin
            r_acc <= f_add_mod(r_acc, r_acc, r_mod);
        end
        if (i_cmd.mul_add) begin
            if (r_b[WIDTH-1]) begin
                r_acc <= f_add_mod(r_acc, r_a, r_mod);
            end
            r_b   <= {r_b[WIDTH-2:0], 1'b0};
            r_cnt <= r_cnt + CW'(1);
        end
        if (!i_rst_n) begin
            r_solution <= '0;
            r_status   <= '0;
        end else if (i_cmd.res_load) begin
            r_solution <= (r_st == ST_SOLVED) ? r_acc : '0;
            r_status   <= r_st;
        end
    end

    assign o_sts.in_mod_zero = (i_modulus == '0);
    assign o_sts.cnt_last    = (r_cnt == CW'(WIDTH - 1));
    assign o_sts.r1_zero     = (r_r1 == '0);
    assign o_sts.rem_zero    = (r_rem == '0);
    assign o_solution        = r_solution;
    assign o_status          = r_status;

endmodule

FILE: rtl/lcs_ctrl.sv
// Controller: sequences Euclid steps, divisibility check, reduction, multiply and result transfer.
module lcs_ctrl
    import lcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EU_TEST  = 4'd1;
    localparam logic [3:0] S_EU_DIV   = 4'd2;
    localparam logic [3:0] S_EU_UPD   = 4'd3;
    localparam logic [3:0] S_CK_DIV   = 4'd4;
    localparam logic [3:0] S_CK_TEST  = 4'd5;
    localparam logic [3:0] S_RD_DIV   = 4'd6;
    localparam logic [3:0] S_MUL_INIT = 4'd7;
    localparam logic [3:0] S_MUL_DBL  = 4'd8;
    localparam logic [3:0] S_MUL_ADD  = 4'd9;
    localparam logic [3:0] S_FIN      = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_sts.in_mod_zero ? S_FIN : S_EU_TEST;
                end
            end
            S_EU_TEST: begin
                o_cmd.div_load = 1'b1;
                if (i_sts.r1_zero) begin
                    o_cmd.div_sel = SEL_CHECK;
                    n_state = S_CK_DIV;
                end else begin
                    o_cmd.div_sel = SEL_EUCLID;
                    n_state = S_EU_DIV;
                end
            end
            S_EU_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_EU_UPD;
                end
            end
            S_EU_UPD: begin
                o_cmd.eu_upd = 1'b1;
                n_state = S_EU_TEST;
            end
            S_CK_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_CK_TEST;
                end
            end
            S_CK_TEST: begin
                if (i_sts.rem_zero) begin
                    o_cmd.umod     = 1'b1;
                    o_cmd.div_load = 1'b1;
                    o_cmd.div_sel  = SEL_REDUCE;
                    n_state = S_RD_DIV;
                end else begin
                    o_cmd.st_wr   = 1'b1;
                    o_cmd.st_code = ST_NONE;
                    n_state = S_FIN;
                end
            end
            S_RD_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_MUL_INIT;
                end
            end
            S_MUL_INIT: begin
                o_cmd.mul_init = 1'b1;
                n_state = S_MUL_DBL;
            end
            S_MUL_DBL: begin
                o_cmd.mul_dbl = 1'b1;
                n_state = S_MUL_ADD;
            end
            S_MUL_ADD: begin
                o_cmd.mul_add = 1'b1;
                n_state = i_sts.cnt_last ? S_FIN : S_MUL_DBL;
            end
            S_FIN: begin
                if (!r_ovalid || i_m_tready) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.res_load) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;

endmodule

FILE: rtl/linear_congruence_solver_core.sv
// Top level of the linear congruence solver: stream ports, controller and datapath.
//
// Solves coefficient * x == target (mod modulus) for one input transfer and
// returns one result transfer with the solution and a status code
// (solved, no solution, zero modulus).
// Input channel i_s_*: coefficient, target and modulus packed in i_s_tdata.
// Output channel o_m_*: solution in o_m_tdata, status in o_m_tuser.
// One item is in work at a time; o_s_tready is high only while idle.
// A zero modulus goes straight to the result register. Otherwise the item
// runs the Euclid steps in the bit-per-cycle restoring divider (up to about
// 46 steps at WIDTH = 32), then the divisibility check, the reduction and
// the shift-add modular multiply, and is then loaded into the result register.
// A new item is taken only after the current one is loaded there.
// The result register parts the channels: a new item is taken while a result
// waits; a finished item then holds until the receiver takes the pending one.
// Reset (i_rst_n low, synchronous) returns to idle and drops any pending result.
module linear_congruence_solver_core
    import lcs_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // coefficient, target, modulus (WIDTH bits each), zero pad
    input  logic [((3*WIDTH+7)/8)*8-1:0]  i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // solution (WIDTH bits), zero pad
    output logic [((WIDTH+7)/8)*8-1:0]    o_m_tdata,
    // status (2 bits)
    output logic [STATUS_W-1:0]           o_m_tuser
);

    localparam int OUT_DW = ((WIDTH + 7) / 8) * 8;

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic [WIDTH-1:0] w_solution;

    lcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lcs_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_coefficient (i_s_tdata[WIDTH-1:0]),
        .i_target      (i_s_tdata[2*WIDTH-1:WIDTH]),
        .i_modulus     (i_s_tdata[3*WIDTH-1:2*WIDTH]),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_solution    (w_solution),
        .o_status      (o_m_tuser)
    );

    assign o_m_tdata = OUT_DW'(w_solution);

endmodule
